FILE: rtl/sbac_pkg.sv
// Package for the slot barrier ack collector: constants, codes and transfer types.
package sbac_pkg;

  localparam int NUM_PROXIES    = 64;
  localparam int NUM_COMPONENTS = 64;

  localparam int MASK_W   = 64;
  localparam int SLOT_W   = 8;
  localparam int LEVEL_W  = 3;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 64;

  localparam logic [SLOT_W-1:0]  FIRST_SLOT   = SLOT_W'(2);
  localparam logic [SLOT_W-1:0]  LAST_SLOT    = SLOT_W'(255);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX    = LEVEL_W'(7);
  localparam logic [LEVEL_W-1:0] RESEND_FIRST = LEVEL_W'(4);
  localparam logic [LEVEL_W-1:0] RESEND_LAST  = LEVEL_W'(6);

  // Register index, taken from paddr[3] (registers are 8 bytes apart).
  localparam logic REG_COMPONENT_MASK = 1'b0;

  localparam logic CMD_ACK     = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  localparam logic [7:0] KIND_PROXY     = 8'd1;
  localparam logic [7:0] KIND_COMPONENT = 8'd2;

  typedef enum logic [2:0] {
    ST_ACCEPTED      = 3'd0,
    ST_BAD_KIND      = 3'd1,
    ST_ID_RANGE      = 3'd2,
    ST_UNREGISTERED  = 3'd3,
    ST_DUPLICATE     = 3'd4,
    ST_TIMEOUT       = 3'd5
  } status_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] member_kind;
    logic [7:0] member_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               new_proxy;
    logic               round_done;
    logic [SLOT_W-1:0]  broadcast_slot;
    logic [MASK_W-1:0]  resend_mask;
    logic [MASK_W-1:0]  dropped_mask;
    logic [LEVEL_W-1:0] round_count;
  } out_item_t;

  // Mask of the n low bits, n in 1..64.
  function automatic logic [MASK_W-1:0] low_mask(input int n);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (i < n) m[i] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [MASK_W-1:0] PROXY_MASK     = low_mask(NUM_PROXIES);
  localparam logic [MASK_W-1:0] COMPONENT_MASK = low_mask(NUM_COMPONENTS);

endpackage

FILE: rtl/slot_barrier_ack_collector.sv
// Slot barrier ack collector: per-slot ack bitmaps, timeout rounds and slot release.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+-----------
//  input    | in_valid, in_stall, in_data (in_item_t)   | in
//  result   | out_valid, out_stall, out_data (out_item_t)| out
//  config   | psel, penable, pwrite, paddr, pwdata,     | APB
//           | prdata, pready                            |
//
// One item per cycle while in_stall is low: each accepted item updates the
// bitmaps, timeout round and slot in the cycle it is accepted, and its result
// is registered the next cycle. The result side has an output register and one
// skid register; in_stall rises only while the skid register holds a result.
// Reset (rst, synchronous) clears the bitmaps, timeout round and component mask,
// sets the slot to 2 and empties the result registers.
module slot_barrier_ack_collector (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  sbac_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output sbac_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sbac_pkg::ADDR_W-1:0]  paddr,
  input  logic [sbac_pkg::DATA_W-1:0]  pwdata,
  output logic [sbac_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  logic [sbac_pkg::MASK_W-1:0]  component_mask;
  logic [sbac_pkg::MASK_W-1:0]  proxy_active, proxy_active_next;
  logic [sbac_pkg::MASK_W-1:0]  proxy_acked, proxy_acked_next;
  logic [sbac_pkg::MASK_W-1:0]  component_acked, component_acked_next;
  logic [sbac_pkg::LEVEL_W-1:0] timeout_level, timeout_level_next;
  logic [sbac_pkg::SLOT_W-1:0]  current_slot, current_slot_next;

  sbac_pkg::out_item_t result;
  sbac_pkg::out_item_t skid;
  logic                skid_valid;
  logic                in_xfer;
  logic                cfg_write;

  logic [sbac_pkg::MASK_W-1:0]  id_bit;
  logic [sbac_pkg::MASK_W-1:0]  pending;
  logic [sbac_pkg::LEVEL_W-1:0] level_inc;
  logic                         error;
  logic                         done;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = (paddr[3] == sbac_pkg::REG_COMPONENT_MASK) ? component_mask : '0;

  assign in_stall = skid_valid;
  assign in_xfer  = in_valid & ~in_stall;

  always_comb begin
    proxy_active_next    = proxy_active;
    proxy_acked_next     = proxy_acked;
    component_acked_next = component_acked;
    timeout_level_next   = timeout_level;
    current_slot_next    = current_slot;
    error                = 1'b0;
    done                 = 1'b0;
    id_bit               = sbac_pkg::MASK_W'(1) << in_data.member_id;
    level_inc            = (timeout_level < sbac_pkg::LEVEL_MAX) ?
                           timeout_level + sbac_pkg::LEVEL_W'(1) : timeout_level;
    pending              = '0;

    result                = '0;
    result.status         = sbac_pkg::ST_ACCEPTED;
    result.broadcast_slot = current_slot;

    if (in_data.cmd == sbac_pkg::CMD_TIMEOUT) begin
      result.status      = sbac_pkg::ST_TIMEOUT;
      timeout_level_next = level_inc;
      pending            = proxy_active & ~proxy_acked & sbac_pkg::PROXY_MASK;
      if (level_inc >= sbac_pkg::RESEND_FIRST && level_inc <= sbac_pkg::RESEND_LAST) begin
        result.resend_mask = pending;
      end else if (level_inc == sbac_pkg::LEVEL_MAX) begin
        result.dropped_mask = pending;
        proxy_active_next   = proxy_active & ~pending;
      end
    end else if (in_data.member_kind == sbac_pkg::KIND_PROXY) begin
      if (32'(in_data.member_id) >= 32'(sbac_pkg::NUM_PROXIES)) begin
        result.status = sbac_pkg::ST_ID_RANGE;
        error         = 1'b1;
      end else begin
        if ((proxy_active & id_bit) == '0) begin
          proxy_active_next = proxy_active | id_bit;
          result.new_proxy  = 1'b1;
        end
        if ((proxy_acked & id_bit) != '0) begin
          result.status = sbac_pkg::ST_DUPLICATE;
          error         = 1'b1;
        end else begin
          proxy_acked_next = proxy_acked | id_bit;
        end
      end
    end else if (in_data.member_kind == sbac_pkg::KIND_COMPONENT) begin
      if (32'(in_data.member_id) >= 32'(sbac_pkg::NUM_COMPONENTS)) begin
        result.status = sbac_pkg::ST_ID_RANGE;
        error         = 1'b1;
      end else if ((component_mask & id_bit) == '0) begin
        result.status = sbac_pkg::ST_UNREGISTERED;
        error         = 1'b1;
      end else if ((component_acked & id_bit) != '0) begin
        result.status = sbac_pkg::ST_DUPLICATE;
        error         = 1'b1;
      end else begin
        component_acked_next = component_acked | id_bit;
      end
    end else begin
      result.status = sbac_pkg::ST_BAD_KIND;
      error         = 1'b1;
    end

    // All-acked check runs on the updated bitmaps.
    done = error |
           (((proxy_active_next & ~proxy_acked_next & sbac_pkg::PROXY_MASK) == '0) &&
            ((component_mask & ~component_acked_next & sbac_pkg::COMPONENT_MASK) == '0));

    if (done) begin
      proxy_acked_next     = '0;
      component_acked_next = '0;
      timeout_level_next   = '0;
      current_slot_next    = (current_slot == sbac_pkg::LAST_SLOT) ?
                             sbac_pkg::FIRST_SLOT : current_slot + sbac_pkg::SLOT_W'(1);
    end

    result.round_done  = done;
    result.round_count = timeout_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      component_mask <= '0;
    end else if (cfg_write && paddr[3] == sbac_pkg::REG_COMPONENT_MASK) begin
      component_mask <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proxy_active    <= '0;
      proxy_acked     <= '0;
      component_acked <= '0;
      timeout_level   <= '0;
      current_slot    <= sbac_pkg::FIRST_SLOT;
    end else if (in_xfer) begin
      proxy_active    <= proxy_active_next;
      proxy_acked     <= proxy_acked_next;
      component_acked <= component_acked_next;
      timeout_level   <= timeout_level_next;
      current_slot    <= current_slot_next;
    end
  end

  // Output register plus skid: park a new result when the held one is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        out_data   <= skid;
        skid_valid <= 1'b0;
      end
    end else if (in_xfer) begin
      if (out_valid && out_stall) begin
        skid       <= result;
        skid_valid <= 1'b1;
      end else begin
        out_data  <= result;
        out_valid <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: tb/sbac_checker.sv
// Checker for the slot barrier ack collector: predicts every result and compares transfers.
module sbac_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  sbac_pkg::in_item_t           in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  sbac_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [sbac_pkg::ADDR_W-1:0]  paddr,
  input  logic [sbac_pkg::DATA_W-1:0]  pwdata,
  output int                           mismatches,
  output int                           outstanding,
  output int                           results_checked
);
  import sbac_pkg::*;

  logic [MASK_W-1:0]  comp_mask;
  logic [MASK_W-1:0]  proxies_on;
  logic [MASK_W-1:0]  proxies_acked;
  logic [MASK_W-1:0]  comps_acked;
  logic [LEVEL_W-1:0] tmo_level;
  logic [SLOT_W-1:0]  slot;

  out_item_t          slot_results_q[$];
  out_item_t          want;

  // Apply one item to the barrier state and return the result it causes.
  function automatic out_item_t advance_barrier(input in_item_t it);
    out_item_t         r;
    logic              err;
    logic [MASK_W-1:0] id_bit;
    logic [MASK_W-1:0] waiting;
    r = '0;
    err = 1'b0;
    r.broadcast_slot = slot;
    id_bit = MASK_W'(1) << it.member_id;
    if (it.cmd == CMD_TIMEOUT) begin
      r.status = ST_TIMEOUT;
      if (tmo_level != LEVEL_MAX) tmo_level = tmo_level + LEVEL_W'(1);
      waiting = proxies_on & ~proxies_acked & PROXY_MASK;
      if (tmo_level >= RESEND_FIRST && tmo_level <= RESEND_LAST) begin
        r.resend_mask = waiting;
      end else if (tmo_level == LEVEL_MAX) begin
        r.dropped_mask = waiting;
        proxies_on = proxies_on & ~waiting;
      end
    end else if (it.member_kind != KIND_PROXY && it.member_kind != KIND_COMPONENT) begin
      r.status = ST_BAD_KIND;
      err = 1'b1;
    end else if (it.member_kind == KIND_PROXY) begin
      if (32'(it.member_id) >= 32'(NUM_PROXIES)) begin
        r.status = ST_ID_RANGE;
        err = 1'b1;
      end else begin
        // activation sticks even when the ack turns out to be a duplicate
        if ((proxies_on & id_bit) == '0) begin
          proxies_on = proxies_on | id_bit;
          r.new_proxy = 1'b1;
        end
        if ((proxies_acked & id_bit) != '0) begin
          r.status = ST_DUPLICATE;
          err = 1'b1;
        end else begin
          proxies_acked = proxies_acked | id_bit;
        end
      end
    end else begin
      if (32'(it.member_id) >= 32'(NUM_COMPONENTS)) begin
        r.status = ST_ID_RANGE;
        err = 1'b1;
      end else if ((comp_mask & id_bit) == '0) begin
        r.status = ST_UNREGISTERED;
        err = 1'b1;
      end else if ((comps_acked & id_bit) != '0) begin
        r.status = ST_DUPLICATE;
        err = 1'b1;
      end else begin
        comps_acked = comps_acked | id_bit;
      end
    end
    if (err || ((proxies_on & ~proxies_acked & PROXY_MASK) == '0 &&
                (comp_mask & ~comps_acked & COMPONENT_MASK) == '0)) begin
      r.round_done = 1'b1;
      proxies_acked = '0;
      comps_acked = '0;
      tmo_level = '0;
      slot = (slot == LAST_SLOT) ? FIRST_SLOT : slot + SLOT_W'(1);
    end
    r.round_count = tmo_level;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      comp_mask = '0;
      proxies_on = '0;
      proxies_acked = '0;
      comps_acked = '0;
      tmo_level = '0;
      slot = FIRST_SLOT;
      slot_results_q.delete();
      mismatches = 0;
      results_checked = 0;
    end else begin
      // the result of an item accepted at this edge cannot leave before the next one
      if (out_valid && !out_stall) begin
        results_checked++;
        if (slot_results_q.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with nothing expected, got %0h", $time, out_data);
        end else begin
          want = slot_results_q.pop_front();
          check_field("status", 64'(want.status), 64'(out_data.status));
          check_field("new_proxy", 64'(want.new_proxy), 64'(out_data.new_proxy));
          check_field("round_done", 64'(want.round_done), 64'(out_data.round_done));
          check_field("broadcast_slot", 64'(want.broadcast_slot),
                      64'(out_data.broadcast_slot));
          check_field("resend_mask", want.resend_mask, out_data.resend_mask);
          check_field("dropped_mask", want.dropped_mask, out_data.dropped_mask);
          check_field("round_count", 64'(want.round_count), 64'(out_data.round_count));
        end
      end
      if (in_valid && !in_stall) slot_results_q.push_back(advance_barrier(in_data));
      if (psel && penable && pwrite && pready && paddr[3] == REG_COMPONENT_MASK)
        comp_mask = pwdata;
    end
    outstanding = slot_results_q.size();
  end

endmodule

FILE: tb/tb.sv
// Top of the slot barrier ack collector testbench: clock, reset, stimulus and verdict.
module tb;
  import sbac_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int                  mismatches;
  int                  outstanding;
  int                  results_checked;

  bit                  idle_on = 1'b1;
  int                  stall_left = 0;
  int                  items_sent = 0;
  int                  mask_writes = 0;
  logic [7:0]          pool_ids[0:7];
  int                  pool_n = 0;
  logic [MASK_W-1:0]   cur_mask = '0;
  in_item_t            round_list[0:79];
  int                  list_n;

  slot_barrier_ack_collector dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sbac_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .outstanding(outstanding),
    .results_checked(results_checked)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("%0t: timeout, %0d results still outstanding", $time, outstanding);
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: draw a stall after every result transfer while idle_on is set.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        stall_left = idle_on ? $urandom_range(0, 12) : 0;
        if (stall_left != 0) out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_stall <= 1'b0;
      end
    end
  end

  function automatic in_item_t make_item(input logic cmd, input logic [7:0] kind,
                                         input logic [7:0] id);
    in_item_t it;
    it.cmd = cmd;
    it.member_kind = kind;
    it.member_id = id;
    return it;
  endfunction

  function automatic in_item_t tick_item();
    return make_item(CMD_TIMEOUT, 8'($urandom), 8'($urandom));
  endfunction

  // Errors and stray acks mixed into otherwise well-formed rounds.
  function automatic in_item_t noise_item();
    case ($urandom_range(0, 3))
      0: return make_item(CMD_ACK, 8'($urandom), 8'($urandom));
      1: return make_item(CMD_ACK, KIND_PROXY, 8'($urandom));
      2: return make_item(CMD_ACK, KIND_COMPONENT, 8'($urandom));
      default: begin
        if (pool_n == 0) return make_item(CMD_ACK, KIND_PROXY, 8'($urandom_range(0, 63)));
        return make_item(CMD_ACK, KIND_PROXY, pool_ids[$urandom_range(0, pool_n - 1)]);
      end
    endcase
  endfunction

  task automatic push_item(input in_item_t it);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has been seen.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mask(input logic [MASK_W-1:0] value);
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_COMPONENT_MASK, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    cur_mask = value;
    mask_writes++;
  endtask

  // One round: each pool entry and registered component acks once, in random order.
  task automatic run_round();
    in_item_t tmp;
    int       j;
    int       stuck_at;
    list_n = 0;
    for (int p = 0; p < pool_n; p++) begin
      round_list[list_n] = make_item(CMD_ACK, KIND_PROXY, pool_ids[p]);
      list_n++;
    end
    for (int c = 0; c < MASK_W; c++) begin
      if (cur_mask[c]) begin
        round_list[list_n] = make_item(CMD_ACK, KIND_COMPONENT, 8'(c));
        list_n++;
      end
    end
    for (int k = list_n - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = round_list[k];
      round_list[k] = round_list[j];
      round_list[j] = tmp;
    end
    // now and then stall the round long enough to reach resend and at times drop
    stuck_at = (list_n > 0 && $urandom_range(0, 4) == 0) ? $urandom_range(0, list_n - 1) : -1;
    for (int k = 0; k < list_n; k++) begin
      if (k == stuck_at) repeat ($urandom_range(4, 9)) push_item(tick_item());
      if ($urandom_range(0, 9) == 0) push_item(noise_item());
      if ($urandom_range(0, 11) == 0) push_item(tick_item());
      push_item(round_list[k]);
    end
    if (list_n == 0) push_item(tick_item());
  endtask

  initial begin
    logic [MASK_W-1:0] m;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty barrier, first proxies, a repeat ack and kind, id and mask errors
    push_item(make_item(CMD_TIMEOUT, 8'hFF, 8'hFF));
    push_item(make_item(CMD_ACK, KIND_PROXY, 8'd0));
    push_item(make_item(CMD_ACK, KIND_PROXY, 8'd63));
    push_item(make_item(CMD_ACK, KIND_PROXY, 8'd63));
    push_item(make_item(CMD_ACK, 8'd0, 8'd0));
    push_item(make_item(CMD_ACK, 8'hFF, 8'hFF));
    push_item(make_item(CMD_ACK, KIND_PROXY, 8'd64));
    push_item(make_item(CMD_ACK, KIND_PROXY, 8'hFF));
    push_item(make_item(CMD_ACK, KIND_COMPONENT, 8'd64));
    push_item(make_item(CMD_ACK, KIND_COMPONENT, 8'd5));
    write_mask(64'h8000_0000_0000_0001);
    push_item(make_item(CMD_ACK, KIND_COMPONENT, 8'd0));
    // walk the timeout rounds through resend, drop and saturation, then a duplicate
    repeat (8) push_item(make_item(CMD_TIMEOUT, 8'h00, 8'h00));
    push_item(make_item(CMD_ACK, KIND_COMPONENT, 8'd63));
    push_item(make_item(CMD_ACK, KIND_COMPONENT, 8'd0));
    push_item(make_item(CMD_ACK, KIND_COMPONENT, 8'd0));

    for (int ph = 0; items_sent < 1300; ph++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      m = '0;
      if (ph == 1) m = '1;
      else if (ph != 3) repeat ($urandom_range(0, 5)) m[$urandom_range(0, 63)] = 1'b1;
      write_mask(m);
      if (ph == 3) begin
        // long run of one-item rounds to wrap the slot counter
        repeat (7) push_item(tick_item());
        repeat (300) begin
          if ($urandom_range(0, 7) != 0) push_item(tick_item());
          else push_item(make_item(CMD_ACK, 8'($urandom_range(3, 255)), 8'($urandom)));
        end
      end else begin
        pool_n = (ph == 1) ? 1 : $urandom_range(0, 6);
        for (int p = 0; p < pool_n; p++) pool_ids[p] = 8'($urandom_range(0, 63));
        repeat ((ph == 1) ? 2 : $urandom_range(4, 10)) run_round();
      end
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Summary: %0d items sent under %0d mask settings, %0d results compared,",
             items_sent, mask_writes, results_checked);
    $display("  including timeout resend/drop rounds, every error status and a slot wrap.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sbac_pkg.sv
rtl/slot_barrier_ack_collector.sv
tb/sbac_checker.sv
tb/tb.sv
